// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  // Fixed-point constants. Hue has 7 fraction bits, the rest is Q0.16.
  localparam logic [15:0] HUE_FULL     = 16'd46080;
  localparam logic [15:0] SEXTANT_SPAN = 16'd7680;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  // f = rem * 128 / 15 is done as (rem * RECIP_15) >> RECIP_SHIFT.
  // RECIP_15 = ceil(2^24 / 15); the error stays below one part in 2^20.
  localparam logic [20:0] RECIP_15    = 21'd1118482;
  localparam int unsigned RECIP_SHIFT = 17;

  // Sextant of the color wheel.
  typedef enum logic [2:0] {
    SEXT_RED_YELLOW     = 3'd0,
    SEXT_YELLOW_GREEN   = 3'd1,
    SEXT_GREEN_CYAN     = 3'd2,
    SEXT_CYAN_BLUE      = 3'd3,
    SEXT_BLUE_MAGENTA   = 3'd4,
    SEXT_MAGENTA_RED    = 3'd5
  } sextant_e;

  // Input pixel.
  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [16:0] brightness;
  } pixel_in_t;

  // Output pixel.
  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } pixel_out_t;

  // Front end result: sextant, fraction, saturation, value and the p term.
  typedef struct packed {
    sextant_e    sextant;
    logic [15:0] frac;
    logic [16:0] sat;
    logic [16:0] val;
    logic [16:0] p;
  } front_t;

  // Mixer result: all four candidate channel values.
  typedef struct packed {
    sextant_e    sextant;
    logic [16:0] val;
    logic [16:0] p;
    logic [16:0] q;
    logic [16:0] t;
  } mix_t;

endpackage

// ===== rtl/hsv2rgb_front.sv =====
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  pixel_in_t in_pixel_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output front_t    out_data_o,
  input  logic      out_stall_i
);

  // Stage one registers: split hue, clamped saturation and value.
  logic        s1_vld_q;
  sextant_e    s1_sext_q, s1_sext_d;
  logic [12:0] s1_rem_q, s1_rem_d;
  logic [16:0] s1_sat_q, s1_sat_d;
  logic [16:0] s1_val_q, s1_val_d;

  // Stage two registers.
  logic   s2_vld_q;
  front_t s2_q, s2_d;

  logic        s1_en, s2_en;
  logic [15:0] hue_c;
  logic [15:0] base;
  logic [15:0] rem_full;
  logic [33:0] frac_prod;
  logic [33:0] p_prod;

  // A stage loads when it is empty or its content moves on.
  assign s2_en      = !s2_vld_q || !out_stall_i;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_stall_o = !s1_en;

  // Clamp inputs; a full circle of hue wraps to zero.
  always_comb begin
    hue_c    = (in_pixel_i.hue >= HUE_FULL) ? 16'd0 : in_pixel_i.hue;
    s1_sat_d = (in_pixel_i.saturation > ONE_Q16) ? ONE_Q16 : in_pixel_i.saturation;
    s1_val_d = (in_pixel_i.brightness > ONE_Q16) ? ONE_Q16 : in_pixel_i.brightness;
  end

  // Sextant by comparison against the five boundaries.
  always_comb begin
    if (hue_c >= 16'(5 * SEXTANT_SPAN)) begin
      s1_sext_d = SEXT_MAGENTA_RED;
      base      = 16'(5 * SEXTANT_SPAN);
    end else if (hue_c >= 16'(4 * SEXTANT_SPAN)) begin
      s1_sext_d = SEXT_BLUE_MAGENTA;
      base      = 16'(4 * SEXTANT_SPAN);
    end else if (hue_c >= 16'(3 * SEXTANT_SPAN)) begin
      s1_sext_d = SEXT_CYAN_BLUE;
      base      = 16'(3 * SEXTANT_SPAN);
    end else if (hue_c >= 16'(2 * SEXTANT_SPAN)) begin
      s1_sext_d = SEXT_GREEN_CYAN;
      base      = 16'(2 * SEXTANT_SPAN);
    end else if (hue_c >= SEXTANT_SPAN) begin
      s1_sext_d = SEXT_YELLOW_GREEN;
      base      = SEXTANT_SPAN;
    end else begin
      s1_sext_d = SEXT_RED_YELLOW;
      base      = 16'd0;
    end
    rem_full = hue_c - base;
    s1_rem_d = rem_full[12:0];
  end

  // Stage two: fraction through the sextant, and p = v(1-s).
  always_comb begin
    frac_prod     = {21'd0, s1_rem_q} * {13'd0, RECIP_15};
    p_prod        = {17'd0, s1_val_q} * {17'd0, ONE_Q16 - s1_sat_q};
    s2_d.sextant  = s1_sext_q;
    s2_d.frac     = frac_prod[RECIP_SHIFT +: 16];
    s2_d.sat      = s1_sat_q;
    s2_d.val      = s1_val_q;
    s2_d.p        = p_prod[32:16];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= in_valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_sext_q <= s1_sext_d;
      s1_rem_q  <= s1_rem_d;
      s1_sat_q  <= s1_sat_d;
      s1_val_q  <= s1_val_d;
    end
    if (s2_en && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_vld_q;
  assign out_data_o  = s2_q;

endmodule

// ===== rtl/hsv2rgb_mix.sv =====
module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  front_t in_data_i,
  output logic   in_stall_o,
  output logic   out_valid_o,
  output mix_t   out_data_o,
  input  logic   out_stall_i
);

  // Stage three registers: s*f and s*(1-f).
  logic        s3_vld_q;
  sextant_e    s3_sext_q;
  logic [16:0] s3_val_q, s3_p_q;
  logic [16:0] s3_sf_q, s3_sf_d;
  logic [16:0] s3_sg_q, s3_sg_d;

  // Stage four registers.
  logic s4_vld_q;
  mix_t s4_q, s4_d;

  logic        s3_en, s4_en;
  logic [33:0] sf_prod, sg_prod;
  logic [33:0] q_prod, t_prod;

  assign s4_en      = !s4_vld_q || !out_stall_i;
  assign s3_en      = !s3_vld_q || s4_en;
  assign in_stall_o = !s3_en;

  // Saturation scaled by the fraction and by its complement.
  always_comb begin
    sf_prod = {17'd0, in_data_i.sat} * {18'd0, in_data_i.frac};
    sg_prod = {17'd0, in_data_i.sat} * {17'd0, ONE_Q16 - {1'b0, in_data_i.frac}};
    s3_sf_d = sf_prod[32:16];
    s3_sg_d = sg_prod[32:16];
  end

  // q = v(1-sf) and t = v(1-sg).
  always_comb begin
    q_prod       = {17'd0, s3_val_q} * {17'd0, ONE_Q16 - s3_sf_q};
    t_prod       = {17'd0, s3_val_q} * {17'd0, ONE_Q16 - s3_sg_q};
    s4_d.sextant = s3_sext_q;
    s4_d.val     = s3_val_q;
    s4_d.p       = s3_p_q;
    s4_d.q       = q_prod[32:16];
    s4_d.t       = t_prod[32:16];
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s3_en) s3_vld_q <= in_valid_i;
      if (s4_en) s4_vld_q <= s3_vld_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s3_en && in_valid_i) begin
      s3_sext_q <= in_data_i.sextant;
      s3_val_q  <= in_data_i.val;
      s3_p_q    <= in_data_i.p;
      s3_sf_q   <= s3_sf_d;
      s3_sg_q   <= s3_sg_d;
    end
    if (s4_en && s3_vld_q) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = s4_vld_q;
  assign out_data_o  = s4_q;

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter.
// Input channel: in_valid_i, in_stall_o and in_pixel_i carry hue (degrees
// with 7 fraction bits, 46080 is a full circle), saturation and brightness
// (Q0.16). A transfer happens at a rising edge with valid high and stall low.
// Output channel: out_valid_o, out_stall_i and out_pixel_o carry red, green
// and blue in Q0.16, one result for every input pixel, in order.
// The datapath is a five-stage pipeline: hue split and clamping, fraction
// and p term, the two saturation products, the q and t products, and the
// channel select in the output register. While the receiver does not stall,
// the pipeline takes one pixel per clock; the multiplier pairs of stages two
// to four set the depth. When the receiver stalls, full stages hold their
// contents and empty ones keep filling, so in_stall_o rises only once all
// five stages hold a pixel. Reset clears every valid bit; nothing else
// needs clearing.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  pixel_in_t  in_pixel_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output pixel_out_t out_pixel_o,
  input  logic       out_stall_i
);

  logic       front_vld, front_stall;
  front_t     front_data;
  logic       mix_vld, mix_stall;
  mix_t       mix_data;
  logic       out_vld_q;
  logic       out_en;
  pixel_out_t out_q, out_d;

  hsv2rgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_pixel_i (in_pixel_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(front_vld),
    .out_data_o (front_data),
    .out_stall_i(front_stall)
  );

  hsv2rgb_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (front_vld),
    .in_data_i  (front_data),
    .in_stall_o (front_stall),
    .out_valid_o(mix_vld),
    .out_data_o (mix_data),
    .out_stall_i(mix_stall)
  );

  assign out_en    = !out_vld_q || !out_stall_i;
  assign mix_stall = !out_en;

  // Channel permutation for the sextant.
  always_comb begin
    unique case (mix_data.sextant)
      SEXT_RED_YELLOW: begin
        out_d = '{red: mix_data.val, green: mix_data.t, blue: mix_data.p};
      end
      SEXT_YELLOW_GREEN: begin
        out_d = '{red: mix_data.q, green: mix_data.val, blue: mix_data.p};
      end
      SEXT_GREEN_CYAN: begin
        out_d = '{red: mix_data.p, green: mix_data.val, blue: mix_data.t};
      end
      SEXT_CYAN_BLUE: begin
        out_d = '{red: mix_data.p, green: mix_data.q, blue: mix_data.val};
      end
      SEXT_BLUE_MAGENTA: begin
        out_d = '{red: mix_data.t, green: mix_data.p, blue: mix_data.val};
      end
      default: begin
        out_d = '{red: mix_data.val, green: mix_data.p, blue: mix_data.q};
      end
    endcase
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= mix_vld;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_en && mix_vld) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_q;

  // The input side only stalls when the output is full and held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i))
    else $error("input stalled while the output stage can move");

  // A pixel leaving the mixer lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mix_vld && !mix_stall) |=> out_vld_q)
    else $error("pixel lost between mixer and output stage");

  // Every channel stays within one in Q0.16.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.red <= ONE_Q16 && out_q.green <= ONE_Q16 &&
                   out_q.blue <= ONE_Q16))
    else $error("color channel above full scale");

endmodule

// ===== tb/sv/hsv_to_rgb_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the HSV to RGB converter. Every accepted input
// pixel is converted here, and every accepted output pixel is compared
// against the oldest conversion still waiting.
module hsv_to_rgb_checker import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  pixel_in_t  in_pixel_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  pixel_out_t out_pixel_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int unsigned FRAC_NUM = 128;
  localparam int unsigned FRAC_DEN = 15;

  pixel_out_t rgb_expected_q[$];
  int         mismatch_count = 0;
  int         checked_count  = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = rgb_expected_q.size();
  assign checked_o        = checked_count;

  // Q0.16 product that keeps the bits above the low sixteen.
  function automatic logic [63:0] q16_product(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 16;
  endfunction

  // Expected RGB pixel for one HSV pixel.
  function automatic pixel_out_t convert_hsv(pixel_in_t px);
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] sat_frac;
    logic [63:0] sat_rest;
    logic [16:0] p_term;
    logic [16:0] q_term;
    logic [16:0] t_term;
    sextant_e    sext;
    pixel_out_t  rgb;
    // Clamp to the legal ranges; a full circle folds back to zero.
    hue = (px.hue > HUE_FULL) ? HUE_FULL : px.hue;
    if (hue == HUE_FULL) begin
      hue = '0;
    end
    sat = (px.saturation > ONE_Q16) ? ONE_Q16 : px.saturation;
    val = (px.brightness > ONE_Q16) ? ONE_Q16 : px.brightness;

    // Split the hue into a sextant and a Q0.16 fraction through it.
    sext = sextant_e'(3'(hue / SEXTANT_SPAN));
    rem  = 64'(hue % SEXTANT_SPAN);
    frac = (rem * FRAC_NUM) / FRAC_DEN;

    sat_frac = q16_product(64'(sat), frac);
    sat_rest = q16_product(64'(sat), 64'(ONE_Q16) - frac);
    p_term   = 17'(q16_product(64'(val), 64'(ONE_Q16) - 64'(sat)));
    q_term   = 17'(q16_product(64'(val), 64'(ONE_Q16) - sat_frac));
    t_term   = 17'(q16_product(64'(val), 64'(ONE_Q16) - sat_rest));

    // The sextant picks which term drives each channel.
    case (sext)
      SEXT_RED_YELLOW: begin
        rgb.red = val;    rgb.green = t_term; rgb.blue = p_term;
      end
      SEXT_YELLOW_GREEN: begin
        rgb.red = q_term; rgb.green = val;    rgb.blue = p_term;
      end
      SEXT_GREEN_CYAN: begin
        rgb.red = p_term; rgb.green = val;    rgb.blue = t_term;
      end
      SEXT_CYAN_BLUE: begin
        rgb.red = p_term; rgb.green = q_term; rgb.blue = val;
      end
      SEXT_BLUE_MAGENTA: begin
        rgb.red = t_term; rgb.green = p_term; rgb.blue = val;
      end
      default: begin
        rgb.red = val;    rgb.green = p_term; rgb.blue = q_term;
      end
    endcase
    return rgb;
  endfunction

  // Compare each output transfer first, then record the input transfer.
  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (rgb_expected_q.size() == 0) begin
          $error("output transfer with no pixel outstanding: red %0d green %0d blue %0d",
                 out_pixel_i.red, out_pixel_i.green, out_pixel_i.blue);
          mismatch_count++;
        end else begin
          want = rgb_expected_q.pop_front();
          checked_count++;
          if (out_pixel_i.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_pixel_i.red);
            mismatch_count++;
          end
          if (out_pixel_i.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_pixel_i.green);
            mismatch_count++;
          end
          if (out_pixel_i.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_pixel_i.blue);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rgb_expected_q.push_back(convert_hsv(in_pixel_i));
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Drives HSV pixels into the converter with random gaps and output stalls,
// and reports the verdict from the checker's mismatch count.
module testbench;
  import hsv2rgb_pkg::*;

  localparam int  RANDOM_PIXELS = 1100;
  localparam int  BURST_FIRST   = 400;
  localparam int  BURST_LAST    = 599;
  localparam int  IDLE_PERCENT  = 32;
  localparam int  DRAIN_CYCLES  = 12;
  localparam real TIMEOUT_NS    = 400000.0;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  pixel_in_t  in_pixel  = '0;
  logic       in_stall;
  logic       out_valid;
  pixel_out_t out_pixel;
  logic       out_stall = 1'b0;
  logic       burst_mode = 1'b0;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int directed_count = 0;
  int sent_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hsv_to_rgb_converter uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_pixel_i  (in_pixel),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_pixel_o (out_pixel),
    .out_stall_i (out_stall)
  );

  hsv_to_rgb_checker rgb_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_pixel_i       (in_pixel),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_pixel_i      (out_pixel),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count),
    .checked_o        (checked_count)
  );

  // The receiver stalls at random, except during the burst stretch.
  always @(negedge clk) begin
    out_stall <= burst_mode ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
  end

  // Send one pixel, entered and left at a falling edge. Idle cycles come
  // first, one at a time, so that gaps have a geometric length.
  task automatic send_pixel(input pixel_in_t px);
    bit idle;
    idle = !burst_mode && ($urandom_range(99) < IDLE_PERCENT);
    if (idle) begin
      in_valid <= 1'b0;
      while (idle) begin
        @(negedge clk);
        idle = !burst_mode && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_count++;
    @(negedge clk);
  endtask

  // Q0.16 component: mostly in range, some at the ends, some any pattern.
  function automatic logic [16:0] random_unit();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      return 17'($urandom_range(65536));
    end else if (pick < 85) begin
      return $urandom_range(1) ? ONE_Q16 : 17'd0;
    end
    return 17'($urandom());
  endfunction

  // Hue: mostly in range, some next to a sextant boundary, some any value.
  function automatic logic [15:0] random_hue();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return 16'($urandom_range(46080));
    end else if (pick < 85) begin
      return 16'($urandom_range(6) * 7680 + $urandom_range(2)) - 16'd1;
    end
    return 16'($urandom());
  endfunction

  initial begin
    pixel_in_t directed_q[$];
    pixel_in_t px;
    // Sextant boundaries, full circle, hue above range, and the ends of
    // saturation and brightness including values above one.
    directed_q.push_back('{hue: 16'd0,     saturation: 17'd0,      brightness: 17'd0});
    directed_q.push_back('{hue: 16'd0,     saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd7679,  saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd7680,  saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd15360, saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd23040, saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd30720, saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd38400, saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd46079, saturation: 17'd65536,  brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd46080, saturation: 17'd40000,  brightness: 17'd50000});
    directed_q.push_back('{hue: 16'd46081, saturation: 17'd40000,  brightness: 17'd50000});
    directed_q.push_back('{hue: 16'd65535, saturation: 17'd131071, brightness: 17'd131071});
    directed_q.push_back('{hue: 16'd3840,  saturation: 17'd65537,  brightness: 17'd32768});
    directed_q.push_back('{hue: 16'd11520, saturation: 17'd32768,  brightness: 17'd65537});
    directed_q.push_back('{hue: 16'd19200, saturation: 17'd65535,  brightness: 17'd65535});
    directed_q.push_back('{hue: 16'd26880, saturation: 17'd1,      brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd34560, saturation: 17'd65536,  brightness: 17'd1});
    directed_q.push_back('{hue: 16'd42240, saturation: 17'd0,      brightness: 17'd65536});
    directed_q.push_back('{hue: 16'd1,     saturation: 17'd98304,  brightness: 17'd98304});
    directed_q.push_back('{hue: 16'd32768, saturation: 17'd65536,  brightness: 17'd0});

    // Hold reset, then release it at a falling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_q[i]) begin
      send_pixel(directed_q[i]);
      directed_count++;
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == BURST_FIRST) begin
        burst_mode <= 1'b1;
      end else if (n == BURST_LAST + 1) begin
        burst_mode <= 1'b0;
      end
      px.hue        = random_hue();
      px.saturation = random_unit();
      px.brightness = random_unit();
      send_pixel(px);
    end
    in_valid <= 1'b0;

    // Let the pipeline drain, then wait out the DRAIN_CYCLES margin.
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels (%0d directed, rest random) under random gaps and stalls.",
             sent_count, directed_count);
    $display("Checked %0d RGB results, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", pending_count);
    $display("== FAIL ==");
    $finish;
  end

endmodule
